@@ design/text_console_writer_macros.svh @@
// Assertion macros shared by the text console writer RTL.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is held.
`define TCW_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tcw check failed");
// Next-cycle implication, disabled while reset is held.
`define TCW_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tcw check failed");
`else
`define TCW_ASSERT_IMP(label, clk, rstn, ante, cons)
`define TCW_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

@@ design/tcw_pkg.sv @@
// Shared constants, codes and helpers of the text console writer.
`timescale 1ns / 1ps
package tcw_pkg;

    localparam int DEF_MAX_COLS = 80;
    localparam int DEF_MAX_ROWS = 25;

    // item kinds (s_tuser)
    localparam logic [2:0] KIND_PUT    = 3'd0;
    localparam logic [2:0] KIND_RAW    = 3'd1;
    localparam logic [2:0] KIND_PLOT   = 3'd2;
    localparam logic [2:0] KIND_SETCUR = 3'd3;
    localparam logic [2:0] KIND_CLEAR  = 3'd4;
    localparam logic [2:0] KIND_READ   = 3'd5;

    // register indexes
    localparam logic [1:0] REG_COLUMNS = 2'd0;
    localparam logic [1:0] REG_ROWS    = 2'd1;
    localparam logic [1:0] REG_ATTR    = 2'd2;

    localparam logic [6:0] COLUMNS_RST = 7'd80;
    localparam logic [4:0] ROWS_RST    = 5'd25;
    localparam logic [7:0] ATTR_RST    = 8'd7;

    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // Size register as used: zero acts as one, above the limit acts as the limit.
    function automatic logic [7:0] eff_dim(input logic [7:0] v, input int lim);
        logic [7:0] r;
        if (v == 8'd0) begin
            r = 8'd1;
        end else if (int'(v) > lim) begin
            r = 8'(lim);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

@@ design/text_console_writer.sv @@
// Put, plot, set cursor: result registered in ST_DONE; s_tready low until it is sent.
// Read cell: the same, the cell comes from the screen RAM's registered read port.
// Scroll: rows 1.. move up one row, bottom row zero-filled; one RAM port each way.
// Clear fills every cell, one cell write per cycle through the single write port.
// Reset (aresetn low, synchronous): cursor to 0,0, registers to 80/25/7; screen RAM is not cleared.
`timescale 1ns / 1ps
`include "text_console_writer_macros.svh"
module text_console_writer #(
    parameter int MAX_COLS = tcw_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = tcw_pkg::DEF_MAX_ROWS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // ch[7:0], x_pos[15:8], y_pos[23:16]
    input  logic [2:0]  s_tuser,   // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // cursor_x[6:0], cursor_y[11:7], cell_char[19:12],
                                   // cell_attr[27:20], status[28], zero[31:29]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_COPY = 2'd1;
    localparam logic [1:0] ST_FILL = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    function automatic logic [AW-1:0] addr_of(input logic [4:0] r, input logic [6:0] c);
        return AW'(32'(r) * MAX_COLS + 32'(c));
    endfunction

    logic [1:0]    state_reg, state_next;
    logic [6:0]    cols_reg, cols_next;
    logic [4:0]    rows_reg, rows_next;
    logic [7:0]    attr_reg, attr_next;
    logic [6:0]    col_reg, col_next;
    logic [4:0]    row_reg, row_next;
    logic [6:0]    sw_col_reg, sw_col_next;
    logic [4:0]    sw_row_reg, sw_row_next;
    logic [AW-1:0] sw_base_reg, sw_base_next;
    logic [15:0]   fill_reg, fill_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] pend_addr_reg, pend_addr_next;
    logic          rdok_reg, rdok_next;
    logic          status_reg, status_next;
    logic          m_valid_reg, m_valid_next;
    logic [31:0]   m_data_reg, m_data_next;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr, copy_addr;
    logic [15:0]   ram_wdata, ram_rdata;

    logic [7:0] eff_c8, eff_r8, new_c8, new_r8;
    logic [6:0] eff_cols;
    logic [4:0] eff_rows;
    logic       in_acc, cfg_acc, coord_bad, col_wrap, row_last, sw_col_end, sw_row_end;
    logic       do_raw, do_nl;
    logic [7:0] ch, xp, yp;
    logic [7:0] cell_char, cell_attr;

    tcw_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_screen (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign ch = s_tdata[7:0];
    assign xp = s_tdata[15:8];
    assign yp = s_tdata[23:16];

    assign eff_c8   = tcw_pkg::eff_dim({1'b0, cols_reg}, MAX_COLS);
    assign eff_r8   = tcw_pkg::eff_dim({3'b000, rows_reg}, MAX_ROWS);
    assign eff_cols = eff_c8[6:0];
    assign eff_rows = eff_r8[4:0];
    assign new_c8   = tcw_pkg::eff_dim({1'b0, cfg_data[6:0]}, MAX_COLS);
    assign new_r8   = tcw_pkg::eff_dim({3'b000, cfg_data[4:0]}, MAX_ROWS);

    assign coord_bad  = (xp >= {1'b0, eff_cols}) || (yp >= {3'b000, eff_rows});
    assign col_wrap   = ({1'b0, col_reg} + 8'd1) >= {1'b0, eff_cols};
    assign row_last   = ({1'b0, row_reg} + 6'd1) >= {1'b0, eff_rows};
    assign sw_col_end = ({1'b0, sw_col_reg} + 8'd1) >= {1'b0, eff_cols};
    assign sw_row_end = ({1'b0, sw_row_reg} + 6'd1) >= {1'b0, eff_rows};
    assign copy_addr  = sw_base_reg + AW'(sw_col_reg);

    assign cell_char = rdok_reg ? ram_rdata[7:0]  : 8'd0;
    assign cell_attr = rdok_reg ? ram_rdata[15:8] : 8'd0;

    always_comb begin
        state_next     = state_reg;
        cols_next      = cols_reg;
        rows_next      = rows_reg;
        attr_next      = attr_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        sw_col_next    = sw_col_reg;
        sw_row_next    = sw_row_reg;
        sw_base_next   = sw_base_reg;
        fill_next      = fill_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        rdok_next      = rdok_reg;
        status_next    = status_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;
        do_raw         = 1'b0;
        do_nl          = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    state_next  = ST_DONE;
                    rdok_next   = 1'b0;
                    status_next = 1'b0;
                    case (s_tuser)
                        tcw_pkg::KIND_PUT: begin
                            if (ch == tcw_pkg::CH_NEWLINE) begin
                                do_nl = 1'b1;
                            end else if (ch == tcw_pkg::CH_RETURN) begin
                                col_next = 7'd0;
                            end else if (ch == tcw_pkg::CH_BACKSPACE) begin
                                if (col_reg != 7'd0 || row_reg != 5'd0) begin
                                    if (col_reg == 7'd0) begin
                                        row_next = row_reg - 5'd1;
                                        col_next = eff_cols - 7'd1;
                                    end else begin
                                        col_next = col_reg - 7'd1;
                                    end
                                    ram_we    = 1'b1;
                                    ram_waddr = addr_of(row_next, col_next);
                                    ram_wdata = {attr_reg, tcw_pkg::CH_SPACE};
                                end
                            end else begin
                                do_raw = 1'b1;
                            end
                        end
                        tcw_pkg::KIND_RAW: begin
                            do_raw = 1'b1;
                        end
                        tcw_pkg::KIND_PLOT: begin
                            if (coord_bad) begin
                                status_next = 1'b1;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = addr_of(yp[4:0], xp[6:0]);
                                ram_wdata = {attr_reg, ch};
                            end
                        end
                        tcw_pkg::KIND_SETCUR: begin
                            if (coord_bad) begin
                                status_next = 1'b1;
                            end else begin
                                col_next = xp[6:0];
                                row_next = yp[4:0];
                            end
                        end
                        tcw_pkg::KIND_CLEAR: begin
                            col_next     = 7'd0;
                            row_next     = 5'd0;
                            sw_col_next  = 7'd0;
                            sw_row_next  = 5'd0;
                            sw_base_next = '0;
                            fill_next    = {attr_reg, tcw_pkg::CH_SPACE};
                            state_next   = ST_FILL;
                        end
                        tcw_pkg::KIND_READ: begin
                            if (coord_bad) begin
                                status_next = 1'b1;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = addr_of(yp[4:0], xp[6:0]);
                                rdok_next = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase

                    if (do_raw) begin
                        ram_we    = 1'b1;
                        ram_waddr = addr_of(row_reg, col_reg);
                        ram_wdata = {attr_reg, ch};
                        if (col_wrap) begin
                            do_nl = 1'b1;
                        end else begin
                            col_next = col_reg + 7'd1;
                        end
                    end

                    if (do_nl) begin
                        col_next = 7'd0;
                        if (!row_last) begin
                            row_next = row_reg + 5'd1;
                        end else begin
                            // scroll: copy rows 1.. up by one, then zero the bottom row
                            sw_col_next = 7'd0;
                            fill_next   = 16'h0000;
                            if (eff_rows > 5'd1) begin
                                sw_row_next  = 5'd1;
                                sw_base_next = AW'(MAX_COLS);
                                state_next   = ST_COPY;
                            end else begin
                                sw_row_next  = 5'd0;
                                sw_base_next = '0;
                                state_next   = ST_FILL;
                            end
                        end
                    end
                end
            end
            ST_COPY: begin
                // read this cell now, write it one row up next cycle
                ram_re         = 1'b1;
                ram_raddr      = copy_addr;
                pend_next      = 1'b1;
                pend_addr_next = copy_addr - AW'(MAX_COLS);
                if (pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_addr_reg;
                    ram_wdata = ram_rdata;
                end
                if (sw_col_end) begin
                    sw_col_next = 7'd0;
                    if (sw_row_end) begin
                        state_next = ST_FILL;
                    end else begin
                        sw_row_next  = sw_row_reg + 5'd1;
                        sw_base_next = sw_base_reg + AW'(MAX_COLS);
                    end
                end else begin
                    sw_col_next = sw_col_reg + 7'd1;
                end
            end
            ST_FILL: begin
                ram_we = 1'b1;
                if (pend_reg) begin
                    // last copy beat still owns the write port
                    ram_waddr = pend_addr_reg;
                    ram_wdata = ram_rdata;
                end else begin
                    ram_waddr = copy_addr;
                    ram_wdata = fill_reg;
                    if (sw_col_end) begin
                        sw_col_next = 7'd0;
                        if (sw_row_end) begin
                            state_next = ST_DONE;
                        end else begin
                            sw_row_next  = sw_row_reg + 5'd1;
                            sw_base_next = sw_base_reg + AW'(MAX_COLS);
                        end
                    end else begin
                        sw_col_next = sw_col_reg + 7'd1;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {3'b000, status_reg, cell_attr, cell_char, row_reg, col_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_acc) begin
            case (cfg_index)
                tcw_pkg::REG_COLUMNS: begin
                    cols_next = cfg_data[6:0];
                    if ({1'b0, col_reg} >= new_c8) begin
                        col_next = new_c8[6:0] - 7'd1;
                    end
                end
                tcw_pkg::REG_ROWS: begin
                    rows_next = cfg_data[4:0];
                    if ({3'b000, row_reg} >= new_r8) begin
                        row_next = new_r8[4:0] - 5'd1;
                    end
                end
                tcw_pkg::REG_ATTR: begin
                    attr_next = cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cols_reg    <= tcw_pkg::COLUMNS_RST;
            rows_reg    <= tcw_pkg::ROWS_RST;
            attr_reg    <= tcw_pkg::ATTR_RST;
            col_reg     <= 7'd0;
            row_reg     <= 5'd0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cols_reg    <= cols_next;
            rows_reg    <= rows_next;
            attr_reg    <= attr_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sw_col_reg    <= sw_col_next;
        sw_row_reg    <= sw_row_next;
        sw_base_reg   <= sw_base_next;
        fill_reg      <= fill_next;
        pend_addr_reg <= pend_addr_next;
        rdok_reg      <= rdok_next;
        status_reg    <= status_next;
        m_data_reg    <= m_data_next;
    end

    `TCW_ASSERT_NXT(a_accept_leaves_idle, aclk, aresetn, in_acc, state_reg != ST_IDLE)
    `TCW_ASSERT_IMP(a_cursor_in_area, aclk, aresetn, state_reg == ST_IDLE, (col_reg < eff_cols) && (row_reg < eff_rows))
    `TCW_ASSERT_IMP(a_pend_in_sweep, aclk, aresetn, pend_reg, (state_reg == ST_COPY) || (state_reg == ST_FILL))
    `TCW_ASSERT_IMP(a_waddr_in_range, aclk, aresetn, ram_we, 32'(ram_waddr) < DEPTH)

endmodule

@@ design/tcw_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule
